[design/lcdrf_pkg.sv]
// shared types and constants for the lcd rectangle fill sequencer
package lcdrf_pkg;

  // input beat function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // display controller command bytes
  localparam logic [7:0] CMD_COLUMN    = 8'h2A;
  localparam logic [7:0] CMD_ROW       = 8'h2B;
  localparam logic [7:0] CMD_RAM_WRITE = 8'h2C;

  // configuration register indexes
  localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;

  // header step codes
  localparam logic [3:0] HDR_CMD_COL    = 4'd0;
  localparam logic [3:0] HDR_COL_START_H = 4'd1;
  localparam logic [3:0] HDR_COL_START_L = 4'd2;
  localparam logic [3:0] HDR_COL_END_H  = 4'd3;
  localparam logic [3:0] HDR_COL_END_L  = 4'd4;
  localparam logic [3:0] HDR_CMD_ROW    = 4'd5;
  localparam logic [3:0] HDR_ROW_START_H = 4'd6;
  localparam logic [3:0] HDR_ROW_START_L = 4'd7;
  localparam logic [3:0] HDR_ROW_END_H  = 4'd8;
  localparam logic [3:0] HDR_ROW_END_L  = 4'd9;
  localparam logic [3:0] HDR_CMD_RAMWR  = 4'd10;
  localparam logic [3:0] PIXEL_PHASE    = 4'd11;

  // clipped rectangle from a start beat
  typedef struct packed {
    logic        ok;
    logic [10:0] x;
    logic [10:0] y;
    logic [10:0] w;
    logic [10:0] h;
  } clip_t;

endpackage

[design/lcdrf_if.sv]
// handshake channels for start/tick beats and output byte beats
interface lcdrf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [15:0] fill_rgb;

  modport source (output valid, func, rect_x, rect_y, rect_width, rect_height, fill_rgb,
                  input ready);
  modport sink (input valid, func, rect_x, rect_y, rect_width, rect_height, fill_rgb,
                output ready);
endinterface

interface lcdrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

[design/lcd_rect_fill_sequencer.sv]
// lcd rectangle fill sequencer: start/tick beats in, command and pixel bytes out
// a tick beat's byte passes through the input register and then the output register
// throughput: one beat per cycle unless the output stalls; each tick while busy yields one output byte
// a start beat is absorbed in its processing cycle and never yields an output byte
// synchronous active-low reset clears the pipeline, the busy flag and the header step,
// and loads the panel size registers with 128 by 160
module lcd_rect_fill_sequencer #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  lcdrf_in_if.sink          in_ch,
  lcdrf_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [10:0]       cfg_wdata
);
  import lcdrf_pkg::*;

  // configuration registers
  logic [10:0] panel_width_r;
  logic [10:0] panel_height_r;

  // input register
  logic        s1_valid_r;
  logic        s1_func_r;
  logic [15:0] s1_x_r, s1_y_r, s1_w_r, s1_h_r, s1_rgb_r;

  // fill state
  logic        busy_r, busy_nxt;
  logic [3:0]  hdr_step_r, hdr_step_nxt;
  logic        low_half_r, low_half_nxt;
  logic [10:0] col_start_r, col_start_nxt;
  logic [10:0] col_end_r, col_end_nxt;
  logic [10:0] row_start_r, row_start_nxt;
  logic [10:0] row_end_r, row_end_nxt;
  logic [10:0] width_r, width_nxt;
  logic [10:0] cols_left_r, cols_left_nxt;
  logic [10:0] rows_left_r, rows_left_nxt;
  logic [15:0] color_r, color_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        is_data_r, is_data_nxt;
  logic        last_r, last_nxt;

  logic        advance;
  logic        fire;
  clip_t       clip;
  logic [15:0] col_s16, col_e16, row_s16, row_e16;

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.is_data  = is_data_r;
  assign out_ch.last     = last_r;

  assign col_s16 = {5'd0, col_start_r};
  assign col_e16 = {5'd0, col_end_r};
  assign row_s16 = {5'd0, row_start_r};
  assign row_e16 = {5'd0, row_end_r};

  lcdrf_clip #(.MAX_SIDE(MAX_SIDE)) u_clip (
    .panel_width  (panel_width_r),
    .panel_height (panel_height_r),
    .rect_x       (s1_x_r),
    .rect_y       (s1_y_r),
    .rect_width   (s1_w_r),
    .rect_height  (s1_h_r),
    .clip         (clip)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= 11'd128;
      panel_height_r <= 11'd160;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PANEL_WIDTH:  panel_width_r  <= cfg_wdata;
        REG_PANEL_HEIGHT: panel_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func_r <= in_ch.func;
      s1_x_r    <= in_ch.rect_x;
      s1_y_r    <= in_ch.rect_y;
      s1_w_r    <= in_ch.rect_width;
      s1_h_r    <= in_ch.rect_height;
      s1_rgb_r  <= in_ch.fill_rgb;
    end
  end

  // beat processing: latch a start when idle and on the panel, or emit the next byte for a tick while busy
  always_comb begin
    busy_nxt      = busy_r;
    hdr_step_nxt  = hdr_step_r;
    low_half_nxt  = low_half_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    width_nxt     = width_r;
    cols_left_nxt = cols_left_r;
    rows_left_nxt = rows_left_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    is_data_nxt   = is_data_r;
    last_nxt      = last_r;

    if (fire) begin
      if (s1_func_r == FUNC_START) begin
        if (!busy_r && clip.ok) begin
          col_start_nxt = clip.x;
          col_end_nxt   = clip.x + clip.w - 11'd1;
          row_start_nxt = clip.y;
          row_end_nxt   = clip.y + clip.h - 11'd1;
          width_nxt     = clip.w;
          cols_left_nxt = clip.w;
          rows_left_nxt = clip.h;
          color_nxt     = s1_rgb_r;
          low_half_nxt  = 1'b0;
          hdr_step_nxt  = HDR_CMD_COL;
          busy_nxt      = 1'b1;
        end
      end else if (busy_r) begin
        out_valid_nxt = 1'b1;
        last_nxt      = 1'b0;
        is_data_nxt   = 1'b1;
        if (hdr_step_r != PIXEL_PHASE) begin
          // header: window commands and bounds
          hdr_step_nxt = hdr_step_r + 4'd1;
          case (hdr_step_r)
            HDR_CMD_COL: begin
              out_byte_nxt = CMD_COLUMN;
              is_data_nxt  = 1'b0;
            end
            HDR_COL_START_H: out_byte_nxt = col_s16[15:8];
            HDR_COL_START_L: out_byte_nxt = col_s16[7:0];
            HDR_COL_END_H:   out_byte_nxt = col_e16[15:8];
            HDR_COL_END_L:   out_byte_nxt = col_e16[7:0];
            HDR_CMD_ROW: begin
              out_byte_nxt = CMD_ROW;
              is_data_nxt  = 1'b0;
            end
            HDR_ROW_START_H: out_byte_nxt = row_s16[15:8];
            HDR_ROW_START_L: out_byte_nxt = row_s16[7:0];
            HDR_ROW_END_H:   out_byte_nxt = row_e16[15:8];
            HDR_ROW_END_L:   out_byte_nxt = row_e16[7:0];
            default: begin
              out_byte_nxt = CMD_RAM_WRITE;
              is_data_nxt  = 1'b0;
            end
          endcase
        end else if (!low_half_r) begin
          // pixel high byte
          low_half_nxt = 1'b1;
          out_byte_nxt = color_r[15:8];
        end else begin
          // pixel low byte, step the column and row counters
          low_half_nxt = 1'b0;
          out_byte_nxt = color_r[7:0];
          if (cols_left_r == 11'd1) begin
            if (rows_left_r == 11'd1) begin
              busy_nxt     = 1'b0;
              hdr_step_nxt = HDR_CMD_COL;
              last_nxt     = 1'b1;
            end else begin
              rows_left_nxt = rows_left_r - 11'd1;
              cols_left_nxt = width_r;
            end
          end else begin
            cols_left_nxt = cols_left_r - 11'd1;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      hdr_step_r  <= HDR_CMD_COL;
      low_half_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      hdr_step_r  <= hdr_step_nxt;
      low_half_r  <= low_half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_start_r <= row_start_nxt;
    row_end_r   <= row_end_nxt;
    width_r     <= width_nxt;
    cols_left_r <= cols_left_nxt;
    rows_left_r <= rows_left_nxt;
    color_r     <= color_nxt;
    out_byte_r  <= out_byte_nxt;
    is_data_r   <= is_data_nxt;
    last_r      <= last_nxt;
  end

endmodule

[design/lcdrf_clip.sv]
// rectangle rejection and clipping against the panel size
module lcdrf_clip #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic [10:0]          panel_width,
  input  logic [10:0]          panel_height,
  input  logic [15:0]          rect_x,
  input  logic [15:0]          rect_y,
  input  logic [15:0]          rect_width,
  input  logic [15:0]          rect_height,
  output lcdrf_pkg::clip_t     clip
);
  import lcdrf_pkg::*;

  logic [10:0] pw;
  logic [10:0] ph;
  logic [16:0] x_end;
  logic [16:0] y_end;

  // saturate panel size to the largest supported side
  assign pw = ({5'd0, panel_width} > 16'(MAX_SIDE)) ? 11'(MAX_SIDE) : panel_width;
  assign ph = ({5'd0, panel_height} > 16'(MAX_SIDE)) ? 11'(MAX_SIDE) : panel_height;

  assign x_end = {1'b0, rect_x} + {1'b0, rect_width};
  assign y_end = {1'b0, rect_y} + {1'b0, rect_height};

  // origin on panel and nonzero size, then trim to the panel edge
  always_comb begin
    clip.ok = (rect_x < {5'd0, pw}) && (rect_y < {5'd0, ph}) &&
              (rect_width != 16'd0) && (rect_height != 16'd0);
    clip.x  = rect_x[10:0];
    clip.y  = rect_y[10:0];
    clip.w  = (x_end > {6'd0, pw}) ? (pw - rect_x[10:0]) : rect_width[10:0];
    clip.h  = (y_end > {6'd0, ph}) ? (ph - rect_y[10:0]) : rect_height[10:0];
  end

endmodule

[design/lcdrf_checker.sv]
// port-level checks for the lcd rectangle fill sequencer and their bind
module lcdrf_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       last
);
  import lcdrf_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_data) &&
    $stable(last))
    else $error("output beat changed while stalled");

  // no output beat right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // the final beat is always a pixel data byte
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last |-> is_data)
    else $error("last marked on a command byte");

  // command bytes are only the three window and write commands
  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_data |->
      (out_byte == CMD_COLUMN) || (out_byte == CMD_ROW) || (out_byte == CMD_RAM_WRITE))
    else $error("unexpected command byte");

endmodule

bind lcd_rect_fill_sequencer lcdrf_props u_lcdrf_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .is_data   (out_ch.is_data),
  .last      (out_ch.last)
);
